>>> design/smpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse packet decoder package
// Shared types, constants and the button swap table.
// ----------------------------------------------------------------------------
package smpd_pkg;

  // Number of buttons that are decoded (1 to 3).
  localparam int ButtonCount = 3;
  localparam logic [2:0] ButtonMask = 3'((1 << ButtonCount) - 1);

  // Header byte detection: top five bits must read 10000.
  localparam logic [7:0] HeaderMask  = 8'hF8;
  localparam logic [7:0] HeaderValue = 8'h80;

  // Byte positions: header hunting and the last motion byte of a packet.
  localparam logic [2:0] PosHunt = 3'd0;
  localparam logic [2:0] PosLast = 3'd4;

  // Configuration register indexes.
  localparam logic RegDecoderEnable = 1'b0;

  // Pending event bit for the motion event, after the button bits.
  localparam int MotionBit = 3;

  // Button remapping applied to the inverted button bits of the header.
  localparam logic [2:0] SwapTable [8] = '{
    3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7
  };

  typedef enum logic [1:0] {
    EvRelease = 2'd0,
    EvPress   = 2'd1,
    EvMotion  = 2'd2
  } event_kind_e;

  // Everything one completed packet produces.
  typedef struct packed {
    logic [3:0]        mask;    // bits 0..2 button changes, bit 3 motion
    logic [2:0]        state;   // new button states
    logic signed [8:0] dx;
    logic signed [8:0] dy;
  } smpd_summary_t;

endpackage

>>> design/smpd_assembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse packet assembler
// Hunts for the header, collects the motion bytes and, on the last byte,
// computes button changes and motion sums for the event emitter.
// ----------------------------------------------------------------------------
module smpd_assembler
  import smpd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enable_i,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  output logic [2:0]    pos_o,
  output logic          sum_valid_o,
  output smpd_summary_t sum_o
);

  logic [2:0] pos_q, pos_d;
  logic [2:0] held_q, held_d;
  logic [7:0] pkt_q [4];

  logic [2:0]        new_btn;
  logic signed [8:0] dx, dy;
  logic              take;

  assign take  = accept_i && enable_i;
  assign pos_o = pos_q;

  // Completed packet decode: buttons are active low in the header.
  always_comb begin
    new_btn = SwapTable[~pkt_q[0][2:0]] & ButtonMask;
    dx = 9'(signed'(pkt_q[1])) + 9'(signed'(pkt_q[3]));
    dy = 9'(signed'(pkt_q[2])) + 9'(signed'(rx_byte_i));
    sum_o.mask  = {(dx != '0) || (dy != '0), (new_btn ^ held_q) & ButtonMask};
    sum_o.state = new_btn;
    sum_o.dx    = dx;
    sum_o.dy    = dy;
  end

  // Byte position and button state sequencing.
  always_comb begin
    pos_d       = pos_q;
    held_d      = held_q;
    sum_valid_o = 1'b0;
    if (take) begin
      priority if (pos_q == PosHunt) begin
        if ((rx_byte_i & HeaderMask) == HeaderValue) begin
          pos_d = 3'd1;
        end
      end else if (pos_q == PosLast) begin
        pos_d       = PosHunt;
        held_d      = new_btn;
        sum_valid_o = 1'b1;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosHunt;
      held_q <= '0;
    end else begin
      pos_q  <= pos_d;
      held_q <= held_d;
    end
  end

  // Packet byte storage; the header is written only when it matches.
  always_ff @(posedge clk_i) begin
    if (take && (pos_q != PosLast)) begin
      if (pos_q != PosHunt || (rx_byte_i & HeaderMask) == HeaderValue) begin
        pkt_q[pos_q[1:0]] <= rx_byte_i;
      end
    end
  end

endmodule

>>> design/smpd_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse event emitter
// Holds the pending events of one packet and moves them into the output
// register one per cycle unless stalled, button events first, motion last.
// ----------------------------------------------------------------------------
module smpd_emitter
  import smpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              sum_valid_i,
  input  smpd_summary_t     sum_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_kind_o,
  output logic [1:0]        button_index_o,
  output logic signed [8:0] delta_x_o,
  output logic signed [8:0] delta_y_o,
  output logic              last_of_packet_o
);

  logic [3:0]        pend_q, pend_d;
  logic [2:0]        state_q;
  logic signed [8:0] dx_q, dy_q;
  logic              ov_q, ov_d;
  logic              load;
  logic [3:0]        sel;
  logic [1:0]        sel_idx;

  event_kind_e       kind_q;
  logic [1:0]        idx_q;
  logic signed [8:0] odx_q, ody_q;
  logic              last_q;

  assign busy_o = |pend_q;
  assign load   = (|pend_q) && (!ov_q || !out_stall_i);

  // Lowest pending event goes first.
  always_comb begin
    sel     = '0;
    sel_idx = 2'd0;
    priority if (pend_q[0]) begin
      sel[0] = 1'b1;
      sel_idx = 2'd0;
    end else if (pend_q[1]) begin
      sel[1] = 1'b1;
      sel_idx = 2'd1;
    end else if (pend_q[2]) begin
      sel[2] = 1'b1;
      sel_idx = 2'd2;
    end else if (pend_q[MotionBit]) begin
      sel[MotionBit] = 1'b1;
      sel_idx = 2'd3;
    end else begin
      sel = '0;
    end
  end

  // Pending set and output valid. A new packet only arrives when idle.
  always_comb begin
    pend_d = pend_q;
    ov_d   = ov_q;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    if (load) begin
      pend_d = pend_q & ~sel;
      ov_d   = 1'b1;
    end
    if (sum_valid_i) begin
      pend_d = sum_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  // Packet payload held while its events drain.
  always_ff @(posedge clk_i) begin
    if (sum_valid_i) begin
      state_q <= sum_i.state;
      dx_q    <= sum_i.dx;
      dy_q    <= sum_i.dy;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      last_q <= ((pend_q & ~sel) == '0);
      if (sel[MotionBit]) begin
        kind_q <= EvMotion;
        idx_q  <= 2'd0;
        odx_q  <= dx_q;
        ody_q  <= dy_q;
      end else begin
        kind_q <= state_q[sel_idx] ? EvPress : EvRelease;
        idx_q  <= sel_idx;
        odx_q  <= '0;
        ody_q  <= '0;
      end
    end
  end

  assign out_valid_o      = ov_q;
  assign event_kind_o     = kind_q;
  assign button_index_o   = idx_q;
  assign delta_x_o        = odx_q;
  assign delta_y_o        = ody_q;
  assign last_of_packet_o = last_q;

endmodule

>>> design/serial_mouse_packet_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse packet decoder
// Decodes 5-byte serial mouse packets into button and motion events.
// ----------------------------------------------------------------------------
// Usage:
//   Received bytes enter on the input channel (in_valid_i, in_stall_o,
//   rx_byte_i). Events leave on the output channel (out_valid_o,
//   out_stall_i and the event fields). A transaction completes on a rising
//   edge with valid high and stall low.
//   One byte is taken every cycle unless the input stalls. Only the last
//   motion byte of a packet causes events: up to four (three button
//   changes, then one motion event), which pass through the pending set and
//   the output register and appear one per cycle unless the receiver stalls. The final one carries last_of_packet_o.
//   The input stalls only when a new last byte arrives while events of the
//   previous packet still wait in the event queue; with an unstalled
//   receiver that never happens, since a packet spans five bytes.
//   When the receiver stalls, the output event holds and the queue waits.
//   Reset clears the enable bit, returns to header hunting, releases all
//   held buttons and empties the output. The user must write the enable
//   register (paddr[2] low) while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module serial_mouse_packet_decoder
  import smpd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        event_kind_o,
  output logic [1:0]        button_index_o,
  output logic signed [8:0] delta_x_o,
  output logic signed [8:0] delta_y_o,
  output logic              last_of_packet_o
);

  logic          enable_q, enable_d;
  logic          busy;
  logic [2:0]    pos;
  logic          sum_valid;
  smpd_summary_t sum;

  // Configuration register.
  assign pready = 1'b1;

  always_comb begin
    enable_d = enable_q;
    if (psel && penable && pwrite && (paddr[2] == RegDecoderEnable)) begin
      enable_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else begin
      enable_q <= enable_d;
    end
  end

  assign prdata = (paddr[2] == RegDecoderEnable) ? {31'd0, enable_q} : '0;

  // Hold off a completing byte while the event queue is still draining.
  assign in_stall_o = enable_q && (pos == PosLast) && busy;

  smpd_assembler u_asm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable_q),
    .accept_i    (in_valid_i && !in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .pos_o       (pos),
    .sum_valid_o (sum_valid),
    .sum_o       (sum)
  );

  smpd_emitter u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sum_valid_i      (sum_valid),
    .sum_i            (sum),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_kind_o     (event_kind_o),
    .button_index_o   (button_index_o),
    .delta_x_o        (delta_x_o),
    .delta_y_o        (delta_y_o),
    .last_of_packet_o (last_of_packet_o)
  );

endmodule

>>> design/smpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse packet decoder checker
// Port-level assertions on the event channel, bound to the top level.
// ----------------------------------------------------------------------------
module smpd_checker
  import smpd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        event_kind_o,
  input logic [1:0]        button_index_o,
  input logic signed [8:0] delta_x_o,
  input logic signed [8:0] delta_y_o,
  input logic              last_of_packet_o
);

  // A stalled event keeps its valid and payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_kind_o) &&
    $stable(delta_x_o) && $stable(delta_y_o) && $stable(last_of_packet_o))
    else $error("stalled event changed");

  // Button events name a decoded button and carry no motion.
  a_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == EvRelease || event_kind_o == EvPress) |->
    button_index_o < 2'(ButtonCount) && delta_x_o == '0 && delta_y_o == '0)
    else $error("malformed button event");

  // Motion events carry motion, button index zero, and end their packet.
  a_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o == EvMotion |->
    (delta_x_o != '0 || delta_y_o != '0) && button_index_o == '0 &&
    last_of_packet_o)
    else $error("malformed motion event");

  // Button events of one packet come in button order.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_packet_o && event_kind_o != EvMotion
    ##1 out_valid_o && event_kind_o != EvMotion |-> button_index_o >
    $past(button_index_o))
    else $error("button events out of order");

endmodule

bind serial_mouse_packet_decoder smpd_checker u_smpd_checker (.*);

>>> tb/tb_serial_mouse_packet_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial mouse packet decoder testbench
// Drives received bytes into the decoder and checks every button and motion
// event against a behavioral predictor. A short directed table covers the
// corners, then random phases mix well-formed packets with broken packets and
// line noise, with the enable register changed between phases.
// ----------------------------------------------------------------------------
module tb_serial_mouse_packet_decoder;
  import smpd_pkg::*;

  localparam int IdlePercent   = 24;
  localparam int DrainCycles   = 4;
  localparam int WatchdogLimit = 1000;
  localparam int PhaseBytes    = 33;

  // One expected event on the output channel.
  typedef struct packed {
    event_kind_e       kind;
    logic [1:0]        button;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic              last_flag;
  } mouse_event_t;

  typedef enum logic [1:0] {
    RowConfig,   // write the enable register
    RowQuiet,    // byte that must cause no event
    RowTyped,    // byte that causes the one event given in the row
    RowPredict   // byte whose events come from the predictor
  } row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [7:0]   data;
    mouse_event_t want;
  } stim_row_t;

  localparam mouse_event_t NoEvent = '{EvRelease, 2'd0, 9'sd0, 9'sd0, 1'b0};

  // Directed corners: disabled decoder, hunting noise, header-like data inside
  // a packet, extreme motion sums, all buttons pressed then released, and a
  // packet that changes nothing.
  localparam stim_row_t DirectedRows [25] = '{
    '{RowConfig,  8'h00, NoEvent},
    '{RowQuiet,   8'h80, NoEvent},
    '{RowConfig,  8'h01, NoEvent},
    '{RowQuiet,   8'h00, NoEvent},
    '{RowQuiet,   8'hFF, NoEvent},
    '{RowQuiet,   8'h87, NoEvent},
    '{RowQuiet,   8'h7F, NoEvent},
    '{RowQuiet,   8'h80, NoEvent},
    '{RowQuiet,   8'h7F, NoEvent},
    '{RowTyped,   8'h80, '{EvMotion, 2'd0, 9'sd254, 9'h100, 1'b1}},
    '{RowQuiet,   8'h80, NoEvent},
    '{RowQuiet,   8'h00, NoEvent},
    '{RowQuiet,   8'h00, NoEvent},
    '{RowQuiet,   8'h00, NoEvent},
    '{RowPredict, 8'h00, NoEvent},
    '{RowQuiet,   8'h80, NoEvent},
    '{RowQuiet,   8'h00, NoEvent},
    '{RowQuiet,   8'h00, NoEvent},
    '{RowQuiet,   8'h00, NoEvent},
    '{RowQuiet,   8'h00, NoEvent},
    '{RowQuiet,   8'h87, NoEvent},
    '{RowQuiet,   8'h80, NoEvent},
    '{RowQuiet,   8'h80, NoEvent},
    '{RowQuiet,   8'h80, NoEvent},
    '{RowPredict, 8'h80, NoEvent}
  };

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [2:0]        paddr            = '0;
  logic [31:0]       pwdata           = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [7:0]        rx_byte_i        = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [1:0]        event_kind_o;
  logic [1:0]        button_index_o;
  logic signed [8:0] delta_x_o;
  logic signed [8:0] delta_y_o;
  logic              last_of_packet_o;

  // Predictor state.
  logic       enable_q   = 1'b0;
  logic [2:0] position_q = PosHunt;
  logic [7:0] packet_q [4];
  logic [2:0] held_q     = '0;

  mouse_event_t expected_events [$];
  mouse_event_t seen_event;
  int           mismatch_count = 0;
  int           bytes_sent     = 0;
  int           quiet_cycles   = 0;

  serial_mouse_packet_decoder i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_kind_o     (event_kind_o),
    .button_index_o   (button_index_o),
    .delta_x_o        (delta_x_o),
    .delta_y_o        (delta_y_o),
    .last_of_packet_o (last_of_packet_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // No idling on either side while this stretch of bytes goes through.
  function automatic logic calm_stretch();
    return bytes_sent >= 120 && bytes_sent < 200;
  endfunction

  // Receiver stalls at random.
  always @(posedge clk_i) begin
    out_stall_i <= !calm_stretch() && ($urandom_range(99) < IdlePercent);
  end

  // Works out the events that one accepted byte causes.
  function automatic void decode_rx_byte(input logic [7:0] rx);
    logic [2:0]        pressed;
    logic [2:0]        changed;
    logic signed [8:0] sum_x;
    logic signed [8:0] sum_y;
    logic              has_motion;
    mouse_event_t      ev;
    if (!enable_q) return;
    if (position_q == PosHunt) begin
      if ((rx & HeaderMask) == HeaderValue) begin
        packet_q[0] = rx;
        position_q  = 3'd1;
      end
      return;
    end
    if (position_q != PosLast) begin
      packet_q[position_q[1:0]] = rx;
      position_q = position_q + 3'd1;
      return;
    end
    // Last motion byte: the packet is complete.
    position_q = PosHunt;
    pressed    = SwapTable[~packet_q[0][2:0]] & ButtonMask;
    changed    = (pressed ^ held_q) & ButtonMask;
    sum_x      = $signed({packet_q[1][7], packet_q[1]}) + $signed({packet_q[3][7], packet_q[3]});
    sum_y      = $signed({packet_q[2][7], packet_q[2]}) + $signed({rx[7], rx});
    has_motion = (sum_x != 0) || (sum_y != 0);
    for (int j = 0; j < ButtonCount; j++) begin
      if (changed[j]) begin
        ev           = NoEvent;
        ev.kind      = pressed[j] ? EvPress : EvRelease;
        ev.button    = 2'(j);
        ev.last_flag = !has_motion && ((changed >> (j + 1)) == 0);
        expected_events.push_back(ev);
      end
    end
    held_q = pressed;
    if (has_motion) begin
      expected_events.push_back('{EvMotion, 2'd0, sum_x, sum_y, 1'b1});
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compares each event transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d button %0d dx %0d dy %0d",
                 $time, event_kind_o, button_index_o, delta_x_o, delta_y_o);
        mismatch_count++;
      end else begin
        seen_event = expected_events.pop_front();
        check_field("event_kind", seen_event.kind, event_kind_o);
        check_field("button_index", seen_event.button, button_index_o);
        check_field("delta_x", seen_event.dx, delta_x_o);
        check_field("delta_y", seen_event.dy, delta_y_o);
        check_field("last_of_packet", seen_event.last_flag, last_of_packet_o);
      end
    end
  end

  // Ends the run when neither channel nor the register port moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
      $display("** serial_mouse_packet_decoder: FAILED **");
      $finish;
    end
  end

  // Offers one byte, waits for its transaction and predicts its events.
  task automatic feed_byte(input logic [7:0] rx);
    while (!calm_stretch() && ($urandom_range(99) < IdlePercent)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    decode_rx_byte(rx);
  endtask

  // Holds the sender until every expected event is out and the block settles.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register access; psel stays high so that accesses can follow back to back.
  task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {RegDecoderEnable, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  // Writes the enable register while idle and reads it back.
  task automatic set_decoder_enable(input logic enable);
    logic [31:0] readback;
    wait_idle();
    apb_transfer(1'b1, {31'b0, enable}, readback);
    enable_q = enable;
    apb_transfer(1'b0, '0, readback);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_field("decoder_enable readback", {31'b0, enable}, readback);
  endtask

  function automatic logic [7:0] pick_motion_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      3:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    int         mark;
    int         counted;
    int         packets;
    int         roll;
    int         motion_count;
    logic [7:0] rx;
    logic [7:0] motion [4];

    packets = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].kind == RowConfig) begin
        set_decoder_enable(DirectedRows[i].data[0]);
      end else begin
        mark = expected_events.size();
        feed_byte(DirectedRows[i].data);
        if (DirectedRows[i].kind != RowPredict) begin
          while (expected_events.size() > mark) void'(expected_events.pop_back());
          if (DirectedRows[i].kind == RowTyped) expected_events.push_back(DirectedRows[i].want);
        end
      end
    end

    // Random phases; the decoder is switched off for one of them.
    for (int phase = 0; phase < 8; phase++) begin
      set_decoder_enable(phase != 3);
      if (phase == 3) begin
        repeat (20) feed_byte(8'($urandom()));
      end else begin
        counted = 0;
        while (counted < PhaseBytes) begin
          roll = $urandom_range(99);
          if (roll < 12) begin
            // Line noise.
            feed_byte(8'($urandom()));
            counted++;
          end else begin
            // Mostly whole packets; some are cut short and run into the next.
            motion_count = (roll < 20) ? $urandom_range(3) : 4;
            foreach (motion[k]) motion[k] = pick_motion_byte();
            if ($urandom_range(4) == 0) begin
              motion[2] = 8'h00 - motion[0];
              motion[3] = 8'h00 - motion[1];
            end
            rx = {5'b10000, 3'($urandom_range(7))};
            feed_byte(rx);
            for (int k = 0; k < motion_count; k++) feed_byte(motion[k]);
            counted += 1 + motion_count;
            packets++;
            if (packets % 23 == 4) wait_idle();
          end
        end
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_events.size() == 0) begin
      $display("** serial_mouse_packet_decoder: PASSED **");
    end else begin
      $display("** serial_mouse_packet_decoder: FAILED **");
    end
    $finish;
  end

endmodule
